FILE: rtl/sorted_table_binary_search_unit_macros.svh
// ----------------------------------------------------------------------------
// Sorted table search assertion macros
// Shared concurrent assertion shorthands for the search unit RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table search package
// Field widths, codes and the structs passed between the search modules.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    // Field widths of the stream items.
    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 32;
    localparam int MODE_W     = 2;
    localparam int POSITION_W = 10;
    localparam int OCC_W      = 11;
    localparam int LENGTH_W   = 11;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 24;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_TABLE_LENGTH = 1'b0;

    // Item kinds carried in s_tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ANY   = 2'd0,
        MODE_FIRST = 2'd1,
        MODE_LAST  = 2'd2,
        MODE_COUNT = 2'd3
    } mode_t;

    typedef struct packed {
        logic  start;
        mode_t mode;
    } srch_req_t;

    typedef struct packed {
        logic idle;
        logic done;
    } srch_sts_t;

    typedef struct packed {
        logic                  found;
        logic [POSITION_W-1:0] position;
        logic [OCC_W-1:0]      occurrences;
    } srch_res_t;

endpackage

FILE: rtl/sorted_table_binary_search_unit.sv
// ----------------------------------------------------------------------------
// Sorted table binary search unit
// Loadable table of signed values with first, last, any and count searches.
// ----------------------------------------------------------------------------
// The table lives in one single-port-read RAM of TABLE_DEPTH entries; software
// loads it one entry per write transfer (tuser low) and is expected to keep the
// first table_length entries sorted ascending. A query transfer (tuser high)
// searches those entries with the classic halving search and returns one
// result transfer: found, position and, in count mode, the occurrence count.
// Items are handled one at a time. A query starts from the idle state, issues
// one RAM read per halving step (at most ceil(log2(n+1)) steps per pass for n
// searched entries), then hands the result to the output register; count mode
// runs a second, right-leaning pass when the first pass finds the key. The
// probe loop is serial: each step must see the RAM word read in the previous
// cycle before it can pick the next address. The result register lets the
// next transfer be accepted while a result still waits on m_tready.
// Entries never written read back as whatever the RAM holds.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_index[9:0], entry_value[41:10], key[73:42], mode[75:74], zero pad
    input  logic [stbs_pkg::S_TDATA_W-1:0]      s_tdata,
    // operation[0]
    input  logic                                s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // found[0], position[10:1], occurrences[21:11], zero pad
    output logic [stbs_pkg::M_TDATA_W-1:0]      m_tdata,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stbs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [stbs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [stbs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import stbs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Input field slices.
    logic [INDEX_W-1:0]            in_index;
    logic signed [VALUE_W-1:0]     in_value;
    logic signed [VALUE_W-1:0]     in_key;
    logic [MODE_W-1:0]             in_mode;
    logic signed [VALUE_WIDTH-1:0] value_ext, key_ext;

    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_value = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
    assign in_key   = s_tdata[INDEX_W+2*VALUE_W-1:INDEX_W+VALUE_W];
    assign in_mode  = s_tdata[INDEX_W+2*VALUE_W+MODE_W-1:INDEX_W+2*VALUE_W];

    // Values are sign-extended or cut to the stored width.
    assign value_ext = VALUE_WIDTH'(in_value);
    assign key_ext   = VALUE_WIDTH'(in_key);

    // Configuration register.
    logic [LENGTH_W-1:0]  table_length_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    logic [31:0]          len_w;
    logic [CW-1:0]        len;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_TABLE_LENGTH);
    assign prdata  = (reg_idx == REG_TABLE_LENGTH) ? APB_DATA_W'(table_length_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= '0;
        end else if (cfg_wr) begin
            table_length_reg <= pwdata[LENGTH_W-1:0];
        end
    end

    // A length beyond the table is clamped to the table depth.
    assign len_w = (32'(table_length_reg) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                            : 32'(table_length_reg);
    assign len   = len_w[CW-1:0];

    // Input transfer decode.
    srch_req_t         req;
    srch_sts_t         sts;
    srch_res_t         res;
    logic              in_xfer;
    logic              wr_en;
    logic [31:0]       wr_addr_w;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic              res_take;

    assign s_tready  = sts.idle;
    assign in_xfer   = s_tvalid && s_tready;
    assign wr_addr_w = 32'(in_index);
    // Writes past the table depth are dropped.
    assign wr_en     = in_xfer && (s_tuser == OP_WRITE) && (wr_addr_w < 32'(TABLE_DEPTH));
    assign req.start = in_xfer && (s_tuser == OP_QUERY);
    assign req.mode  = mode_t'(in_mode);

    stbs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_w[AW-1:0]),
        .wr_data (value_ext),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stbs_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_search (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .key      (key_ext),
        .len      (len),
        .res_take (res_take),
        .sts      (sts),
        .res      (res),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (signed'(rd_data))
    );

    // Output register: a finished result moves in whenever the slot is free
    // or is being emptied in the same cycle.
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign res_take = sts.done && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_take) begin
            m_tdata_reg <= M_TDATA_W'({res.occurrences, res.position, res.found});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/stbs_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/stbs_search.sv
// ----------------------------------------------------------------------------
// Sorted table search sequencer
// Halving search over the table RAM, one probe per cycle.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_unit_macros.svh"

module stbs_search #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  stbs_pkg::srch_req_t           req,
    input  logic signed [VALUE_WIDTH-1:0] key,
    input  logic [CW-1:0]                 len,
    input  logic                          res_take,
    output stbs_pkg::srch_sts_t           sts,
    output stbs_pkg::srch_res_t           res,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr,
    input  logic signed [VALUE_WIDTH-1:0] rd_data
);

    import stbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_PROBE  = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    mode_t                         mode_reg, mode_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]                 low_reg, hi_reg;
    logic [AW-1:0]                 mid_reg;
    logic                          hit_reg, hit_next;
    logic                          hit2_reg, hit2_next;
    logic                          second_reg, second_next;
    logic [AW-1:0]                 hit_pos_reg, hit_pos_next;
    logic [AW-1:0]                 first_pos_reg, first_pos_next;

    logic [CW-1:0] bnd_lo, bnd_hi, mid_cw, mid_calc;
    logic          eq, gt, go_left;
    logic [31:0]   pos_w, occ_w;

    assign eq      = (rd_data == key_reg);
    assign gt      = (rd_data > key_reg);
    assign go_left = (mode_reg == MODE_FIRST) || ((mode_reg == MODE_COUNT) && !second_reg);
    assign mid_cw  = CW'(mid_reg);

    // Midpoint of the half-open window [bnd_lo, bnd_hi); only used when it is not empty.
    assign mid_calc = bnd_lo + ((bnd_hi - bnd_lo - CW'(1)) >> 1);
    assign rd_addr  = mid_calc[AW-1:0];

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        hit2_next      = hit2_reg;
        second_next    = second_reg;
        hit_pos_next   = hit_pos_reg;
        first_pos_next = first_pos_reg;
        bnd_lo         = low_reg;
        bnd_hi         = hi_reg;
        rd_en          = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    mode_next   = req.mode;
                    key_next    = key;
                    hit_next    = 1'b0;
                    hit2_next   = 1'b0;
                    second_next = 1'b0;
                    bnd_lo      = '0;
                    bnd_hi      = len;
                    if (len != '0) begin
                        rd_en      = 1'b1;
                        state_next = S_PROBE;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_PROBE: begin
                if (eq && (mode_reg == MODE_ANY)) begin
                    hit_next     = 1'b1;
                    hit_pos_next = mid_reg;
                    state_next   = S_FINISH;
                end else begin
                    if (eq) begin
                        hit_pos_next = mid_reg;
                        if (second_reg) begin
                            hit2_next = 1'b1;
                        end else begin
                            hit_next = 1'b1;
                        end
                    end
                    if ((eq && go_left) || (!eq && gt)) begin
                        bnd_lo = low_reg;
                        bnd_hi = mid_cw;
                    end else begin
                        bnd_lo = mid_cw + CW'(1);
                        bnd_hi = hi_reg;
                    end
                    if (bnd_lo < bnd_hi) begin
                        rd_en = 1'b1;
                    end else if ((mode_reg == MODE_COUNT) && !second_reg && (hit_reg || eq)) begin
                        // The first occurrence is known; rerun the search leaning right.
                        second_next    = 1'b1;
                        first_pos_next = eq ? mid_reg : hit_pos_reg;
                        bnd_lo         = '0;
                        bnd_hi         = len;
                        rd_en          = 1'b1;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        hit_reg       <= hit_next;
        hit2_reg      <= hit2_next;
        second_reg    <= second_next;
        hit_pos_reg   <= hit_pos_next;
        first_pos_reg <= first_pos_next;
        if (rd_en) begin
            low_reg <= bnd_lo;
            hi_reg  <= bnd_hi;
            mid_reg <= rd_addr;
        end
    end

    // A right-leaning pass that misses leaves the last index at minus one.
    assign occ_w = (hit2_reg ? (32'(hit_pos_reg) + 32'd1) : 32'd0) - 32'(first_pos_reg);
    assign pos_w = 32'(hit_pos_reg);

    always_comb begin
        res.found       = hit_reg;
        res.position    = '0;
        res.occurrences = '0;
        if (hit_reg) begin
            if (mode_reg == MODE_COUNT) begin
                res.occurrences = occ_w[OCC_W-1:0];
            end else begin
                res.position = pos_w[POSITION_W-1:0];
            end
        end
    end

    assign sts.idle = (state_reg == S_IDLE);
    assign sts.done = (state_reg == S_FINISH);

    `STBS_ASSERT_IMPL(a_probe_after_read, aclk, aresetn, state_reg == S_PROBE, $past(rd_en), "probe without a read issued")
    `STBS_ASSERT_IMPL(a_mid_in_window, aclk, aresetn, state_reg == S_PROBE, (mid_cw >= low_reg) && (mid_cw < hi_reg), "probe address outside the search window")
    `STBS_ASSERT_IMPL(a_second_pass_count, aclk, aresetn, (state_reg == S_PROBE) && second_reg, hit_reg && (mode_reg == MODE_COUNT), "second pass without a first hit in count mode")
    `STBS_ASSERT_NEXT(a_result_released, aclk, aresetn, (state_reg == S_FINISH) && res_take, state_reg == S_IDLE, "taken result did not release the sequencer")

endmodule
